// ----- hdl/jlsp_pkg.sv -----
// Shared constants, types and helpers for the jerk-limited servo profiler.
// No dependencies; used by jlsp_iter_unit and jerk_limited_servo_profile.
`timescale 1ns / 1ps

package jlsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IVL_BITS  = 16;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PWM_OFFSET     = 3'd0;
    localparam logic [2:0] REG_PWM_SPAN       = 3'd1;
    localparam logic [2:0] REG_RANGE_DEG      = 3'd2;
    localparam logic [2:0] REG_ACCEL_JERK     = 3'd3;
    localparam logic [2:0] REG_DECEL_JERK     = 3'd4;
    localparam logic [2:0] REG_DECEL_DISTANCE = 3'd5;
    localparam logic [2:0] REG_CRUISE_SPEED   = 3'd6;
    localparam logic [2:0] REG_DEADBAND       = 3'd7;

    // motion phase codes
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // reset values
    localparam logic [15:0] RST_PWM_OFFSET = 16'd1000;
    localparam logic [15:0] RST_PWM_SPAN   = 16'd1000;
    localparam logic [24:0] RST_RANGE_DEG  = 25'(64'd180 << FRAC_BITS);
    localparam logic [30:0] RST_DEADBAND   = 31'(64'd1 << (FRAC_BITS - 1));

    // iteration counts of the shared unit
    localparam int DIV_STEPS  = 48;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sh080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // magnitude of a signed 32-bit value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

// ----- hdl/jerk_limited_servo_profile.sv -----
// Jerk-limited servo profiler top level: configuration, sequencer, shared multiplier.
// Depends on jlsp_pkg and jlsp_iter_unit.
`timescale 1ns / 1ps

// Sequencing: a start beat goes straight to the result. A tick beat reads back the angle
//   and tests deadband and phase, ending there in deadband or complete; accelerate or
//   decelerate updates accel and speed, cruise skips that, the cruise/decel turn runs the
//   square root; then clamp, position and the pwm divide (skipped when the position is
//   not positive) on the shared divide/root unit (48 or 32 steps). Throughput: one beat
//   at a time; next input accepted in the cycle after the result beat goes.
// Reset (rst_n, async low): registers to their defaults, profile state cleared, pwm at
//   offset, phase accelerate, no result pending.
module jerk_limited_servo_profile (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [24:0] target_position,
    input  logic [15:0] interval,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pwm_out,
    output logic        done_res,
    output logic [1:0]  phase
);

    typedef enum logic [4:0] {
        S_IDLE, S_RB_MUL, S_RB_DIV, S_RB_WAIT, S_DECIDE,
        S_ACC_MUL, S_ACC_ADD, S_SPD_MUL, S_SPD_ADD,
        S_SQ_MUL, S_SQ_X6, S_SQ_GO, S_SQ_WAIT,
        S_CLAMP, S_POS_MUL, S_POS_ADD, S_PWM_MUL, S_PWM_DIV, S_PWM_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] pwm_offset_reg;
    logic [15:0] pwm_span_reg;
    logic [24:0] range_deg_reg;
    logic [30:0] accel_jerk_reg;
    logic [30:0] decel_jerk_reg;
    logic [30:0] decel_distance_reg;
    logic [30:0] cruise_speed_reg;
    logic [30:0] deadband_reg;

    // profile state
    logic signed [31:0] position_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] accel_reg;
    logic [15:0]        pwm_value_reg;
    logic [1:0]         motion_phase_reg;
    logic [24:0]        goal_reg;

    // working registers
    logic [15:0] ivl_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [63:0] sq_reg;
    logic [49:0] adiff_reg;

    // result beat
    logic        out_valid_reg;
    logic [15:0] out_pwm_reg;
    logic        out_done_reg;
    logic [1:0]  out_phase_reg;

    // shared unit
    jlsp_pkg::unit_cmd_t  ucmd;
    jlsp_pkg::unit_stat_t ustat;
    logic [63:0]          u_operand;
    logic [24:0]          u_divisor;
    logic [47:0]          u_result;

    // multiplier operands
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // combinational helpers
    logic signed [16:0] dp;
    logic [31:0]        dp_mag;
    logic [24:0]        span_nz;
    logic [24:0]        rng_nz;
    logic signed [31:0] cs_s;
    logic [31:0]        step_mag;
    logic signed [33:0] step_s;
    logic signed [31:0] sum_sat;
    logic signed [31:0] spd_new;
    logic signed [49:0] back_s;
    logic signed [49:0] diff_s;
    logic [65:0]        x6;
    logic [15:0]        term16;
    logic [16:0]        pwm_sum;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pwm_out   = out_pwm_reg;
    assign done_res  = out_done_reg;
    assign phase     = out_phase_reg;

    assign dp      = $signed({1'b0, pwm_value_reg}) - $signed({1'b0, pwm_offset_reg});
    assign dp_mag  = jlsp_pkg::mag32(32'(dp));
    assign span_nz = (pwm_span_reg == 16'd0) ? 25'd1 : {9'd0, pwm_span_reg};
    assign rng_nz  = (range_deg_reg == 25'd0) ? 25'd1 : range_deg_reg;
    assign cs_s    = $signed({1'b0, cruise_speed_reg});

    // interval product: Q0.16 scale, magnitude always below 2^31
    assign step_mag = prod_reg[47:16];

    always_comb
    begin
        step_s  = neg_reg ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
        sum_sat = '0;
        unique case (state_reg)
            S_ACC_ADD:
                sum_sat = (motion_phase_reg == jlsp_pkg::PH_DECEL)
                        ? jlsp_pkg::sat32(34'(accel_reg) - $signed({2'b00, step_mag}))
                        : jlsp_pkg::sat32(34'(accel_reg) + $signed({2'b00, step_mag}));
            S_SPD_ADD:
                sum_sat = (motion_phase_reg == jlsp_pkg::PH_DECEL)
                        ? jlsp_pkg::sat32(34'(speed_reg) - step_s)
                        : jlsp_pkg::sat32(34'(speed_reg) + step_s);
            S_POS_ADD:
                sum_sat = jlsp_pkg::sat32(34'(position_reg) + step_s);
            default:
                sum_sat = '0;
        endcase
        spd_new = sum_sat;
    end

    // readback angle and distance to the goal
    always_comb
    begin
        back_s = neg_reg ? -$signed({2'b00, u_result}) : $signed({2'b00, u_result});
        diff_s = $signed({25'd0, goal_reg}) - back_s;
    end

    assign x6 = {prod_reg, 2'b00} + {1'b0, prod_reg, 1'b0};

    assign term16  = (u_result > 48'd65535) ? 16'hFFFF : u_result[15:0];
    assign pwm_sum = {1'b0, pwm_offset_reg} + {1'b0, term16};

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_RB_MUL:
            begin
                mul_a = {16'd0, dp_mag[15:0]};
                mul_b = {7'd0, range_deg_reg};
            end
            S_ACC_MUL:
            begin
                mul_a = (motion_phase_reg == jlsp_pkg::PH_DECEL) ? {1'b0, decel_jerk_reg}
                                                                 : {1'b0, accel_jerk_reg};
                mul_b = {16'd0, ivl_reg};
            end
            S_SPD_MUL:
            begin
                mul_a = jlsp_pkg::mag32(accel_reg);
                mul_b = {16'd0, ivl_reg};
            end
            S_SQ_MUL:
            begin
                mul_a = {1'b0, decel_jerk_reg};
                mul_b = {1'b0, decel_distance_reg};
            end
            S_POS_MUL:
            begin
                mul_a = jlsp_pkg::mag32(speed_reg);
                mul_b = {16'd0, ivl_reg};
            end
            S_PWM_MUL:
            begin
                mul_a = position_reg;
                mul_b = {16'd0, pwm_span_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // shared unit command
    always_comb
    begin
        ucmd.start     = (state_reg == S_RB_DIV) || (state_reg == S_SQ_GO)
                      || (state_reg == S_PWM_DIV);
        ucmd.sqrt_mode = (state_reg == S_SQ_GO);
        u_operand      = (state_reg == S_SQ_GO) ? sq_reg : {prod_reg[47:0], 16'd0};
        u_divisor      = (state_reg == S_PWM_DIV) ? rng_nz : span_nz;
    end

    jlsp_iter_unit u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ucmd),
        .operand (u_operand),
        .divisor (u_divisor),
        .stat    (ustat),
        .result  (u_result)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            pwm_offset_reg     <= jlsp_pkg::RST_PWM_OFFSET;
            pwm_span_reg       <= jlsp_pkg::RST_PWM_SPAN;
            range_deg_reg      <= jlsp_pkg::RST_RANGE_DEG;
            accel_jerk_reg     <= '0;
            decel_jerk_reg     <= '0;
            decel_distance_reg <= '0;
            cruise_speed_reg   <= '0;
            deadband_reg       <= jlsp_pkg::RST_DEADBAND;
            position_reg       <= '0;
            speed_reg          <= '0;
            accel_reg          <= '0;
            pwm_value_reg      <= jlsp_pkg::RST_PWM_OFFSET;
            motion_phase_reg   <= jlsp_pkg::PH_ACCEL;
            goal_reg           <= '0;
            out_valid_reg      <= 1'b0;
            out_pwm_reg        <= '0;
            out_done_reg       <= 1'b0;
            out_phase_reg      <= '0;
            ivl_reg            <= '0;
            neg_reg            <= 1'b0;
            sq_reg             <= '0;
            adiff_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jlsp_pkg::REG_PWM_OFFSET:     pwm_offset_reg     <= cfg_data[15:0];
                    jlsp_pkg::REG_PWM_SPAN:       pwm_span_reg       <= cfg_data[15:0];
                    jlsp_pkg::REG_RANGE_DEG:      range_deg_reg      <= cfg_data[24:0];
                    jlsp_pkg::REG_ACCEL_JERK:     accel_jerk_reg     <= cfg_data;
                    jlsp_pkg::REG_DECEL_JERK:     decel_jerk_reg     <= cfg_data;
                    jlsp_pkg::REG_DECEL_DISTANCE: decel_distance_reg <= cfg_data;
                    jlsp_pkg::REG_CRUISE_SPEED:   cruise_speed_reg   <= cfg_data;
                    jlsp_pkg::REG_DEADBAND:       deadband_reg       <= cfg_data;
                    default:                      ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ivl_reg <= interval;
                        if (req_type)
                        begin
                            // start beat: new goal, back to accelerate
                            goal_reg         <= target_position;
                            motion_phase_reg <= jlsp_pkg::PH_ACCEL;
                            out_pwm_reg      <= pwm_value_reg;
                            out_done_reg     <= 1'b0;
                            out_phase_reg    <= jlsp_pkg::PH_ACCEL;
                            out_valid_reg    <= 1'b1;
                            state_reg        <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RB_MUL;
                        end
                    end
                end
                S_RB_MUL:
                begin
                    neg_reg   <= dp[16];
                    state_reg <= S_RB_DIV;
                end
                S_RB_DIV:
                    state_reg <= S_RB_WAIT;
                S_RB_WAIT:
                begin
                    if (ustat.done)
                    begin
                        adiff_reg <= diff_s[49] ? 50'(-diff_s) : 50'(diff_s);
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (adiff_reg < {19'd0, deadband_reg})
                    begin
                        // inside deadband: snap to goal, pwm kept
                        position_reg     <= $signed({7'd0, goal_reg});
                        speed_reg        <= '0;
                        accel_reg        <= '0;
                        motion_phase_reg <= jlsp_pkg::PH_DONE;
                        out_pwm_reg      <= pwm_value_reg;
                        out_done_reg     <= 1'b1;
                        out_phase_reg    <= jlsp_pkg::PH_DONE;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_OUT;
                    end
                    else if (motion_phase_reg == jlsp_pkg::PH_DONE)
                    begin
                        out_pwm_reg   <= pwm_value_reg;
                        out_done_reg  <= 1'b1;
                        out_phase_reg <= jlsp_pkg::PH_DONE;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else if (motion_phase_reg == jlsp_pkg::PH_CRUISE)
                    begin
                        accel_reg <= '0;
                        speed_reg <= cs_s;
                        if (adiff_reg <= {19'd0, decel_distance_reg})
                            state_reg <= S_SQ_MUL;
                        else
                            state_reg <= S_CLAMP;
                    end
                    else
                    begin
                        state_reg <= S_ACC_MUL;
                    end
                end
                S_ACC_MUL:
                    state_reg <= S_ACC_ADD;
                S_ACC_ADD:
                begin
                    accel_reg <= sum_sat;
                    state_reg <= S_SPD_MUL;
                end
                S_SPD_MUL:
                begin
                    neg_reg   <= accel_reg[31];
                    state_reg <= S_SPD_ADD;
                end
                S_SPD_ADD:
                begin
                    if (motion_phase_reg == jlsp_pkg::PH_DECEL)
                    begin
                        if (spd_new <= 32'sd0)
                        begin
                            // decel reached rest
                            accel_reg        <= '0;
                            speed_reg        <= '0;
                            motion_phase_reg <= jlsp_pkg::PH_DONE;
                        end
                        else
                        begin
                            speed_reg <= spd_new;
                        end
                    end
                    else
                    begin
                        speed_reg <= spd_new;
                        if (spd_new >= cs_s)
                            motion_phase_reg <= jlsp_pkg::PH_CRUISE;
                    end
                    state_reg <= S_CLAMP;
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_X6;
                S_SQ_X6:
                begin
                    sq_reg    <= (x6[65:64] != 2'b00) ? {64{1'b1}} : x6[63:0];
                    state_reg <= S_SQ_GO;
                end
                S_SQ_GO:
                    state_reg <= S_SQ_WAIT;
                S_SQ_WAIT:
                begin
                    if (ustat.done)
                    begin
                        accel_reg        <= u_result[31] ? 32'sh7FFFFFFF
                                                         : $signed(u_result[31:0]);
                        motion_phase_reg <= jlsp_pkg::PH_DECEL;
                        state_reg        <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    if (speed_reg > cs_s)
                        speed_reg <= cs_s;
                    else if (speed_reg < -cs_s)
                        speed_reg <= -cs_s;
                    state_reg <= S_POS_MUL;
                end
                S_POS_MUL:
                begin
                    neg_reg   <= speed_reg[31];
                    state_reg <= S_POS_ADD;
                end
                S_POS_ADD:
                begin
                    position_reg <= sum_sat;
                    state_reg    <= S_PWM_MUL;
                end
                S_PWM_MUL:
                begin
                    if (position_reg[31] || (position_reg == 32'sd0))
                    begin
                        // term clamps to zero
                        pwm_value_reg <= pwm_offset_reg;
                        out_pwm_reg   <= pwm_offset_reg;
                        out_done_reg  <= 1'b0;
                        out_phase_reg <= motion_phase_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_PWM_DIV;
                    end
                end
                S_PWM_DIV:
                    state_reg <= S_PWM_WAIT;
                S_PWM_WAIT:
                begin
                    if (ustat.done)
                    begin
                        pwm_value_reg <= pwm_sum[16] ? 16'hFFFF : pwm_sum[15:0];
                        out_pwm_reg   <= pwm_sum[16] ? 16'hFFFF : pwm_sum[15:0];
                        out_done_reg  <= 1'b0;
                        out_phase_reg <= motion_phase_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("input open while result pending");
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_phase_reg == jlsp_pkg::PH_DONE))
        else $error("done result without complete phase");
    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POS_MUL) |-> ((speed_reg <= cs_s) && (speed_reg >= -cs_s)))
        else $error("speed beyond cruise limit");
`endif

endmodule

// ----- hdl/jlsp_iter_unit.sv -----
// Shared shift-subtract unit: restoring divide (1 bit/cycle) or square root (1 root bit/cycle, 2 operand bits each).
// Depends on jlsp_pkg.
`timescale 1ns / 1ps

module jlsp_iter_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jlsp_pkg::unit_cmd_t   cmd,
    input  logic [63:0]           operand,
    input  logic [24:0]           divisor,
    output jlsp_pkg::unit_stat_t  stat,
    output logic [47:0]           result
);

    logic        busy_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] opnd_reg;
    logic [34:0] rem_reg;
    logic [47:0] q_reg;
    logic [24:0] dvs_reg;

    logic [34:0] shifted;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] rem_next;

    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[32:0], opnd_reg[63:62]};
            trial   = {q_reg[32:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[33:0], opnd_reg[63]};
            trial   = {10'd0, dvs_reg};
        end
        ge       = (shifted >= trial);
        rem_next = ge ? (shifted - trial) : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.sqrt_mode;
                cnt_reg  <= cmd.sqrt_mode ? 6'(jlsp_pkg::SQRT_STEPS - 1)
                                          : 6'(jlsp_pkg::DIV_STEPS - 1);
                opnd_reg <= operand;
                rem_reg  <= '0;
                q_reg    <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                q_reg    <= {q_reg[46:0], ge};
                opnd_reg <= mode_reg ? {opnd_reg[61:0], 2'b00} : {opnd_reg[62:0], 1'b0};
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = q_reg;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("unit done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("unit restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("unit done without work");
`endif

endmodule
